[sv/elias_fano_block_encoder_defines.svh]
// Assertion macros shared by the encoder RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef ELIAS_FANO_BLOCK_ENCODER_DEFINES_SVH
`define ELIAS_FANO_BLOCK_ENCODER_DEFINES_SVH

// Same-cycle implication.
`define EFE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define EFE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/efe_pkg.sv]
// Shared types and constants of the Elias-Fano block encoder.
// No dependencies; the queue, front, back and top level import it.
package efe_pkg;

    localparam int FILE_SELECT_BITS_DEF = 6;

    // request and result kinds
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_SUFFIX  = 2'd1;
    localparam logic [1:0] KIND_VALUE   = 2'd2;
    localparam logic [1:0] KIND_IGNORED = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_PREFIX_BITS = 2'd0;
    localparam logic [1:0] CFG_SUFFIX_BITS = 2'd1;
    localparam logic [1:0] CFG_WIDE_VALUES = 2'd2;

    localparam logic [5:0] PREFIX_BITS_RST = 6'd12;
    localparam logic [6:0] SUFFIX_BITS_RST = 7'd32;
    localparam logic [6:0] MAX_WIDTH       = 7'd64;
    localparam logic [6:0] NARROW_WIDTH    = 7'd32;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // flag bit positions
    localparam int FLAG_FILE  = 0;
    localparam int FLAG_UNDER = 1;
    localparam int FLAG_ORDER = 2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  unary_width;
        logic [6:0]  binary_width;
        logic [5:0]  file_index;
        logic [25:0] block_index;
        logic [2:0]  flags;
        logic [63:0] word;
        logic [6:0]  payload_width;
    } efe_entry_t;

    typedef struct packed {
        logic       push;
        efe_entry_t entry;
    } efe_push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } efe_qstat_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [5:0]  unary_width;
        logic [6:0]  binary_width;
        logic [5:0]  file_index;
        logic [25:0] block_index;
        logic [63:0] unary_gap;
        logic [63:0] payload;
        logic [6:0]  payload_width;
        logic [2:0]  error_flags;
    } efe_result_t;

endpackage

[sv/efe_if.sv]
// Channel interfaces of the encoder: request, result and configuration write.
// Depends on no other file.
interface efe_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [31:0] block_prefix;
    logic [31:0] item_count;
    logic [63:0] data_word;

    modport source (output valid, output req_type, output block_prefix,
                    output item_count, output data_word, input ready);
    modport sink   (input valid, input req_type, input block_prefix,
                    input item_count, input data_word, output ready);
endinterface

interface efe_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [5:0]  unary_width;
    logic [6:0]  binary_width;
    logic [5:0]  file_index;
    logic [25:0] block_index;
    logic [63:0] unary_gap;
    logic [63:0] payload;
    logic [6:0]  payload_width;
    logic [2:0]  error_flags;

    modport source (output valid, output result_kind, output unary_width,
                    output binary_width, output file_index, output block_index,
                    output unary_gap, output payload, output payload_width,
                    output error_flags, input ready);
    modport sink   (input valid, input result_kind, input unary_width,
                    input binary_width, input file_index, input block_index,
                    input unary_gap, input payload, input payload_width,
                    input error_flags, output ready);
endinterface

interface efe_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [6:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/efe_queue.sv]
// Two-entry queue between the classifying front and the stateful back.
// Depends on efe_pkg and the assertion macros.
`include "elias_fano_block_encoder_defines.svh"

module efe_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  efe_pkg::efe_push_t   push_in,
    input  logic                 pop,
    output efe_pkg::efe_entry_t  head,
    output efe_pkg::efe_qstat_t  stat
);
    import efe_pkg::*;

    efe_entry_t          mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign stat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push_in.push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_in.entry;
        end
    end

    `EFE_ASSERT_IMPL(a_no_push_full, push_in.push, !stat.full, "push into a full queue")
    `EFE_ASSERT_IMPL(a_no_pop_empty, pop, !stat.empty, "pop from an empty queue")
    `EFE_ASSERT_NEXT(a_count_track, 1'b1,
        count_reg == $past(count_reg) + QCNT_W'($past(do_push)) - QCNT_W'($past(do_pop)),
        "queue fill count lost track")

endmodule

[sv/efe_front.sv]
// Front end: configuration registers, request acceptance and header math.
// Depends on efe_pkg and efe_if.
module efe_front #(
    parameter int FILE_SELECT_BITS = efe_pkg::FILE_SELECT_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    efe_req_if.sink             req,
    efe_cfg_if.sink             cfg,
    input  efe_pkg::efe_qstat_t qstat,
    output efe_pkg::efe_push_t  push_out
);
    import efe_pkg::*;

    logic [5:0]  prefix_bits_reg;
    logic [6:0]  suffix_bits_reg;
    logic        wide_values_reg;

    logic [31:0] thermo;
    logic [5:0]  ubits;
    logic [6:0]  sbits;
    logic        under;
    logic [6:0]  bbits;
    logic [5:0]  blk_bits;
    logic [31:0] fidx;
    logic [31:0] bmask;
    logic [31:0] bidx;
    efe_entry_t  entry;

    assign cfg.ready = 1'b1;
    assign req.ready = !qstat.full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_bits_reg <= PREFIX_BITS_RST;
            suffix_bits_reg <= SUFFIX_BITS_RST;
            wide_values_reg <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_PREFIX_BITS: prefix_bits_reg <= cfg.data[5:0];
                CFG_SUFFIX_BITS: suffix_bits_reg <= cfg.data;
                CFG_WIDE_VALUES: wide_values_reg <= cfg.data[0];
                default:         ;
            endcase
        end
    end

    // ceil(log2(count)) is the number of powers of two below the count
    always_comb
    begin
        for (int u = 0; u < 32; u++)
        begin
            thermo[u] = ({1'b0, req.item_count} > (33'd1 << u));
        end
    end

    assign ubits    = 6'($countones(thermo));
    assign sbits    = (suffix_bits_reg > MAX_WIDTH) ? MAX_WIDTH : suffix_bits_reg;
    assign under    = (sbits < {1'b0, ubits});
    assign bbits    = under ? 7'd0 : sbits - {1'b0, ubits};
    assign blk_bits = (prefix_bits_reg > 6'(FILE_SELECT_BITS))
                    ? prefix_bits_reg - 6'(FILE_SELECT_BITS) : 6'd0;
    assign fidx     = req.block_prefix >> blk_bits;
    assign bmask    = ~(32'hFFFF_FFFF << blk_bits);
    assign bidx     = req.block_prefix & bmask;

    always_comb
    begin
        entry = '0;
        entry.kind = req.req_type;
        unique case (req.req_type)
            KIND_HEADER:
            begin
                entry.unary_width        = ubits;
                entry.binary_width       = bbits;
                entry.file_index         = fidx[5:0];
                entry.block_index        = bidx[25:0];
                entry.flags[FLAG_FILE]   = ((fidx >> FILE_SELECT_BITS) != 32'd0);
                entry.flags[FLAG_UNDER]  = under;
            end
            KIND_SUFFIX:
            begin
                entry.word = req.data_word;
            end
            KIND_VALUE:
            begin
                entry.word          = wide_values_reg ? req.data_word
                                                      : {32'd0, req.data_word[31:0]};
                entry.payload_width = wide_values_reg ? MAX_WIDTH : NARROW_WIDTH;
            end
            default:
            begin
                entry.kind = req.req_type;
            end
        endcase
    end

    // drop the unused request code without a result
    assign push_out.push  = req.valid && req.ready && (req.req_type != KIND_IGNORED);
    assign push_out.entry = entry;

endmodule

[sv/efe_back.sv]
// Back end: block state, suffix split into gap and low bits, value pass-through, result register.
// Depends on efe_pkg, efe_if and the assertion macros.
`include "elias_fano_block_encoder_defines.svh"

module efe_back (
    input  logic                clk,
    input  logic                rst_n,
    input  efe_pkg::efe_entry_t head,
    input  efe_pkg::efe_qstat_t qstat,
    output logic                pop,
    efe_res_if.source           res
);
    import efe_pkg::*;

    logic [63:0] last_high_reg, last_high_next;
    logic [6:0]  low_width_reg, low_width_next;
    logic        out_valid_reg, out_valid_next;
    efe_result_t out_reg, out_next;

    logic [63:0] high;
    logic [63:0] lmask;

    assign pop   = !qstat.empty && (!out_valid_reg || res.ready);
    assign high  = head.word >> low_width_reg;
    assign lmask = ~(64'hFFFF_FFFF_FFFF_FFFF << low_width_reg);

    always_comb
    begin
        last_high_next = last_high_reg;
        low_width_next = low_width_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_next       = out_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
            out_next = '0;
            out_next.result_kind = head.kind;
            case (head.kind)
                KIND_HEADER:
                begin
                    out_next.unary_width  = head.unary_width;
                    out_next.binary_width = head.binary_width;
                    out_next.file_index   = head.file_index;
                    out_next.block_index  = head.block_index;
                    out_next.error_flags  = head.flags;
                    low_width_next        = head.binary_width;
                    last_high_next        = '0;
                end
                KIND_SUFFIX:
                begin
                    out_next.binary_width            = low_width_reg;
                    out_next.unary_gap               = high - last_high_reg;
                    out_next.payload                 = head.word & lmask;
                    out_next.payload_width           = low_width_reg;
                    out_next.error_flags[FLAG_ORDER] = (high < last_high_reg);
                    last_high_next                   = high;
                end
                default:
                begin
                    out_next.payload       = head.word;
                    out_next.payload_width = head.payload_width;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_high_reg <= '0;
            low_width_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            last_high_reg <= last_high_next;
            low_width_reg <= low_width_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign res.valid         = out_valid_reg;
    assign res.result_kind   = out_reg.result_kind;
    assign res.unary_width   = out_reg.unary_width;
    assign res.binary_width  = out_reg.binary_width;
    assign res.file_index    = out_reg.file_index;
    assign res.block_index   = out_reg.block_index;
    assign res.unary_gap     = out_reg.unary_gap;
    assign res.payload       = out_reg.payload;
    assign res.payload_width = out_reg.payload_width;
    assign res.error_flags   = out_reg.error_flags;

    `EFE_ASSERT_NEXT(a_pop_shows, pop, out_valid_reg, "popped word not shown")
    `EFE_ASSERT_NEXT(a_header_state, pop && (head.kind == KIND_HEADER),
        (last_high_reg == 64'd0) && (low_width_reg == $past(head.binary_width)),
        "header did not reset block state")
    `EFE_ASSERT_IMPL(a_width_range, 1'b1, low_width_reg <= MAX_WIDTH,
        "block low width out of range")

endmodule

[sv/elias_fano_block_encoder.sv]
// Top level of the Elias-Fano block encoder.
// Depends on efe_pkg, efe_if, efe_front, efe_queue and efe_back.
//
//   channel  dir   handshake     word
//   req      in    valid/ready   req_type, block_prefix, item_count, data_word
//   res      out   valid/ready   header, suffix code or value result
//   cfg      in    valid/ready   index, data (always ready)
//
// One word per cycle sustained while the result channel is ready; a request
// passes through the queue write, then the back end's result register.
// The back end's 64-bit shift and subtract on the block state sets the pace.
// Reset restores prefix_bits 12, suffix_bits 32, 32-bit values, cleared state.
// A stalled result holds; the two-entry queue keeps taking requests meanwhile until full.
module elias_fano_block_encoder #(
    parameter int FILE_SELECT_BITS = efe_pkg::FILE_SELECT_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    efe_req_if.sink    req,
    efe_res_if.source  res,
    efe_cfg_if.sink    cfg
);
    import efe_pkg::*;

    efe_push_t  push;
    efe_qstat_t qstat;
    efe_entry_t head;
    logic       pop;

    efe_front #(
        .FILE_SELECT_BITS (FILE_SELECT_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .cfg      (cfg),
        .qstat    (qstat),
        .push_out (push)
    );

    efe_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push_in (push),
        .pop     (pop),
        .head    (head),
        .stat    (qstat)
    );

    efe_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .qstat (qstat),
        .pop   (pop),
        .res   (res)
    );

endmodule
